>>> hdl/cfc_pkg.sv
// Types, codes and the CRC-16 byte update shared by the CRC-16 frame checker.
package cfc_pkg;

  // Frame layout
  localparam int unsigned HdrLen  = 3;
  localparam int unsigned TailLen = 2;

  // Largest payload accepted, in bytes (range 1 to 64)
  localparam logic [7:0] MaxPayload = 8'd64;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindStatus  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusShort     = 3'd1,
    StatusTooLarge  = 3'd2,
    StatusLenBad    = 3'd3,
    StatusCrcBad    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    status_e     status;
    logic [7:0]  prefix;
    logic [7:0]  identifier;
    logic [7:0]  declared_len;
    logic [15:0] frame_crc;
  } out_item_t;

  // Reflected CRC-16, one byte, unrolled over its eight bits
  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/crc16_frame_checker_top.sv
// CRC-16 frame checker: byte-stream frame receiver with status on the final byte.
//
// Takes one frame byte per transaction (last_byte set on the final byte) and
// gives exactly one result transaction per input transaction. A frame is
// prefix, identifier, declared payload length, payload, then a CRC-16
// (reflected poly 0xA001, init 0xFFFF) sent low byte first. Payload bytes are
// forwarded as they arrive (kind payload, with their index); the consumer must
// discard them unless the end-of-frame status is ok. The final byte always
// yields a status transaction carrying the header fields and received CRC,
// and the checker then returns to its reset state for the next frame.
// Status priority: too short (< 5 bytes), payload too large (declared length
// above MaxPayload), length mismatch, CRC bad, else ok. The byte count
// saturates at 255. Throughput is one transaction per clock unless stalled; a
// result is valid in the cycle after input accept. The critical path is the
// unrolled 8-bit CRC update followed by the 16-bit CRC compare. The input
// stalls only while a result sits in the output register and the output is stalled.
module crc16_frame_checker_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cfc_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cfc_pkg::out_item_t   out_data_o
);

  // Per-frame state
  logic [7:0]  byte_count_q, byte_count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d;   // older byte of the hold line
  logic [7:0]  held1_q, held1_d;
  logic [7:0]  prefix_q, prefix_d;
  logic [7:0]  ident_q, ident_d;
  logic [7:0]  decl_len_q, decl_len_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  cfc_pkg::out_item_t out_data_q, out_data_d;

  logic       accept;
  logic [7:0] total;      // saturated count including this byte
  logic [7:0] pay_pos;    // position after the header
  logic [8:0] expect_len;
  logic [15:0] rx_crc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    // CRC lags the input by two bytes so the CRC field itself is never fed
    crc_d      = (byte_count_q >= 8'(cfc_pkg::TailLen)) ? cfc_pkg::crc_feed(crc_q, held0_q)
                                                        : crc_q;
    held0_d    = held1_q;
    held1_d    = in_data_i.data_byte;
    prefix_d   = (byte_count_q == 8'd0) ? in_data_i.data_byte : prefix_q;
    ident_d    = (byte_count_q == 8'd1) ? in_data_i.data_byte : ident_q;
    decl_len_d = (byte_count_q == 8'd2) ? in_data_i.data_byte : decl_len_q;
    total      = (byte_count_q == 8'hFF) ? 8'hFF : byte_count_q + 8'd1;
    pay_pos    = byte_count_q - 8'(cfc_pkg::HdrLen);
    expect_len = 9'(cfc_pkg::HdrLen + cfc_pkg::TailLen) + {1'b0, decl_len_d};
    rx_crc     = {held1_d, held0_d};

    out_data_d = '0;
    if (in_data_i.last_byte) begin
      out_data_d.kind = cfc_pkg::KindStatus;
      if (total < 8'(cfc_pkg::HdrLen + cfc_pkg::TailLen)) begin
        out_data_d.status = cfc_pkg::StatusShort;
      end else if (decl_len_d > cfc_pkg::MaxPayload) begin
        out_data_d.status = cfc_pkg::StatusTooLarge;
      end else if (expect_len != {1'b0, total}) begin
        out_data_d.status = cfc_pkg::StatusLenBad;
      end else if (rx_crc != crc_d) begin
        out_data_d.status = cfc_pkg::StatusCrcBad;
      end else begin
        out_data_d.status = cfc_pkg::StatusOk;
      end
      out_data_d.prefix       = prefix_d;
      out_data_d.identifier   = ident_d;
      out_data_d.declared_len = decl_len_d;
      out_data_d.frame_crc    = rx_crc;
    end else if (byte_count_q >= 8'(cfc_pkg::HdrLen) && pay_pos < decl_len_d &&
                 pay_pos < cfc_pkg::MaxPayload) begin
      out_data_d.kind          = cfc_pkg::KindPayload;
      out_data_d.payload_byte  = in_data_i.data_byte;
      out_data_d.payload_index = pay_pos[5:0];
    end

    byte_count_d = total;
    // End of frame: everything returns to reset values
    if (in_data_i.last_byte) begin
      byte_count_d = '0;
      crc_d        = cfc_pkg::CrcInit;
      held0_d      = '0;
      held1_d      = '0;
      prefix_d     = '0;
      ident_d      = '0;
      decl_len_d   = '0;
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q        <= cfc_pkg::CrcInit;
      held0_q      <= '0;
      held1_q      <= '0;
      prefix_q     <= '0;
      ident_q      <= '0;
      decl_len_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        byte_count_q <= byte_count_d;
        crc_q        <= crc_d;
        held0_q      <= held0_d;
        held1_q      <= held1_d;
        prefix_q     <= prefix_d;
        ident_q      <= ident_d;
        decl_len_q   <= decl_len_d;
      end
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Final byte clears the frame state
  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_byte |=> byte_count_q == 8'd0 && crc_q == cfc_pkg::CrcInit)
    else $error("frame state not cleared after final byte");

  // Count advances by one per non-final byte until it saturates
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_data_i.last_byte && byte_count_q != 8'hFF
    |=> byte_count_q == $past(byte_count_q) + 8'd1)
    else $error("byte count did not advance");

  // A final byte always yields a status result
  a_last_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_byte |=> out_valid_o && out_data_o.kind == cfc_pkg::KindStatus)
    else $error("final byte without status result");

  // Non-status results carry no status code
  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != cfc_pkg::KindStatus
    |-> out_data_o.status == cfc_pkg::StatusOk)
    else $error("status code outside end-of-frame result");

endmodule
